### rtl/core/itp_pkg.sv
// itp_pkg: shared constants and types for the infix-to-postfix converter.
// Token and result codes, stack entry layout, sequencer states.
// No dependencies.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    localparam int KIND_W = 3;
    localparam int ID_W   = 8;
    localparam int PRIO_W = 2;
    localparam int PAIR_W = 2;
    localparam int CODE_W = 2;

    // input token kinds
    localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POSTFIX = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREFIX  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BINARY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OPEN    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] OUT_OPERAND = 3'd0;
    localparam logic [KIND_W-1:0] OUT_POSTFIX = 3'd1;
    localparam logic [KIND_W-1:0] OUT_PREFIX  = 3'd2;
    localparam logic [KIND_W-1:0] OUT_BINARY  = 3'd3;
    localparam logic [KIND_W-1:0] OUT_END     = 3'd4;
    localparam logic [KIND_W-1:0] OUT_ERROR   = 3'd5;

    // error codes
    localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] ERR_BRACKET  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        CLS_PREFIX = 2'd0,
        CLS_BINARY = 2'd1,
        CLS_OPEN   = 2'd2
    } entry_cls_t;

    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        entry_cls_t        cls;
    } stack_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] code;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EVAL  = 2'd1,
        ST_FLUSH = 2'd2
    } seq_state_t;

endpackage

`default_nettype wire

### rtl/core/itp_if.sv
// itp_token_if / itp_result_if: valid/ready channels for token requests
// and postfix results. Depends on itp_pkg.
`default_nettype none

interface itp_token_if;
    import itp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   token_id;
    logic [PRIO_W-1:0] priority_req;
    logic [PAIR_W-1:0] bracket_pair;

    modport source (output valid, kind, token_id, priority_req, bracket_pair, input ready);
    modport sink   (input valid, kind, token_id, priority_req, bracket_pair, output ready);
endinterface

interface itp_result_if;
    import itp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [ID_W-1:0]   out_id;
    logic [CODE_W-1:0] error_code;
    logic              last_of_run;

    modport source (output valid, out_kind, out_id, error_code, last_of_run, input ready);
    modport sink   (input valid, out_kind, out_id, error_code, last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/core/infix_to_postfix_converter.sv
// infix_to_postfix_converter: shunting-yard reordering of infix tokens into postfix.
// Depends on itp_pkg and the channel interfaces in itp_if.sv.
//
// Tokens are taken one request at a time; the block is not ready while a token is
// in work. Operators are popped off the stack one by one; the single stack read port
// delivers one entry per cycle while the result side does not stall. The stack holds
// STACK_DEPTH entries; a push onto a full stack is dropped and reported as an
// overflow error. After an error, tokens are discarded until the end token, which
// returns an end marker carrying the error. An unclosed bracket found by the end
// token instead ends the run with an error result and clears the stack.
`default_nettype none

module infix_to_postfix_converter (
    input  wire            clk,
    input  wire            rst_n,
    itp_token_if.sink      tokens,
    itp_result_if.source   results
);
    import itp_pkg::*;

    seq_state_t        state_reg, state_next;

    logic [KIND_W-1:0] kind_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic [PAIR_W-1:0] pair_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CODE_W-1:0] err_reg, err_next;

    stack_entry_t      stack_mem [STACK_DEPTH];
    stack_entry_t      top_reg;
    stack_entry_t      push_entry;
    logic [CNT_W-1:0]  count_m1;
    logic [IDX_W-1:0]  rd_addr;

    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_last_reg;

    // actions decided in EVAL
    logic              emit_req;
    result_t           emit_res;
    logic              do_pop;
    logic              do_push;
    logic              do_clear;
    logic              do_finish;
    logic              err_set;
    logic [CODE_W-1:0] err_val;

    logic              out_free;
    logic              can_go;
    logic              step;
    logic              move_out;
    logic              stack_full;
    logic              stack_empty;
    result_t           top_res;

    assign out_free    = !out_valid_reg || results.ready;
    assign can_go      = !emit_req || !pend_valid_reg || out_free;
    assign step        = (state_reg == ST_EVAL) && can_go;
    assign stack_full  = (count_reg >= DEPTH_CNT);
    assign stack_empty = (count_reg == '0);

    assign top_res.kind = (top_reg.cls == CLS_BINARY) ? OUT_BINARY : OUT_PREFIX;
    assign top_res.id   = top_reg.id;
    assign top_res.code = ERR_NONE;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tokens.valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (can_go && do_finish)
                    state_next = (emit_req || pend_valid_reg) ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // token evaluation against the top of stack
    always_comb
    begin
        emit_req  = 1'b0;
        emit_res  = '{kind: OUT_ERROR, id: '0, code: ERR_NONE};
        do_pop    = 1'b0;
        do_push   = 1'b0;
        do_clear  = 1'b0;
        do_finish = 1'b1;
        err_set   = 1'b0;
        err_val   = ERR_NONE;
        push_entry.cls  = (kind_reg == KIND_PREFIX) ? CLS_PREFIX :
                          (kind_reg == KIND_OPEN) ? CLS_OPEN : CLS_BINARY;
        push_entry.id   = id_reg;
        push_entry.prio = prio_reg;
        push_entry.pair = pair_reg;

        if (state_reg == ST_EVAL)
        begin
            if (err_reg != ERR_NONE)
            begin
                if (kind_reg == KIND_END)
                begin
                    emit_req = 1'b1;
                    emit_res = '{kind: OUT_END, id: '0, code: err_reg};
                    do_clear = 1'b1;
                    err_set  = 1'b1;
                    err_val  = ERR_NONE;
                end
            end
            else
            begin
                case (kind_reg) inside
                    KIND_OPERAND, KIND_POSTFIX:
                    begin
                        emit_req = 1'b1;
                        emit_res = '{kind: kind_reg, id: id_reg, code: ERR_NONE};
                    end
                    KIND_PREFIX, KIND_OPEN:
                    begin
                        if (stack_full)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{kind: OUT_ERROR, id: '0, code: ERR_OVERFLOW};
                            err_set  = 1'b1;
                            err_val  = ERR_OVERFLOW;
                        end
                        else
                            do_push = 1'b1;
                    end
                    KIND_BINARY:
                    begin
                        if (!stack_empty && top_reg.cls != CLS_OPEN && top_reg.prio >= prio_reg)
                        begin
                            emit_req  = 1'b1;
                            emit_res  = top_res;
                            do_pop    = 1'b1;
                            do_finish = 1'b0;
                        end
                        else if (stack_full)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{kind: OUT_ERROR, id: '0, code: ERR_OVERFLOW};
                            err_set  = 1'b1;
                            err_val  = ERR_OVERFLOW;
                        end
                        else
                            do_push = 1'b1;
                    end
                    KIND_CLOSE:
                    begin
                        if (stack_empty)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{kind: OUT_ERROR, id: '0, code: ERR_BRACKET};
                            err_set  = 1'b1;
                            err_val  = ERR_BRACKET;
                        end
                        else if (top_reg.cls == CLS_OPEN)
                        begin
                            if (top_reg.pair != pair_reg)
                            begin
                                emit_req = 1'b1;
                                emit_res = '{kind: OUT_ERROR, id: '0, code: ERR_BRACKET};
                                err_set  = 1'b1;
                                err_val  = ERR_BRACKET;
                            end
                            else
                                do_pop = 1'b1;
                        end
                        else
                        begin
                            emit_req  = 1'b1;
                            emit_res  = top_res;
                            do_pop    = 1'b1;
                            do_finish = 1'b0;
                        end
                    end
                    KIND_END:
                    begin
                        if (stack_empty)
                        begin
                            emit_req = 1'b1;
                            emit_res = '{kind: OUT_END, id: '0, code: ERR_NONE};
                        end
                        else if (top_reg.cls == CLS_OPEN)
                        begin
                            // unclosed bracket: error ends the run, state is cleared
                            emit_req = 1'b1;
                            emit_res = '{kind: OUT_ERROR, id: '0, code: ERR_BRACKET};
                            do_clear = 1'b1;
                        end
                        else
                        begin
                            emit_req  = 1'b1;
                            emit_res  = top_res;
                            do_pop    = 1'b1;
                            do_finish = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // stack pointer, error flag, result holding stage
    always_comb
    begin
        count_next      = count_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        move_out        = 1'b0;

        if (step)
        begin
            if (do_clear)
                count_next = '0;
            else if (do_pop)
                count_next = count_reg - 1'b1;
            else if (do_push)
                count_next = count_reg + 1'b1;
            if (err_set)
                err_next = err_val;
            if (emit_req)
            begin
                pend_valid_next = 1'b1;
                move_out        = pend_valid_reg;
            end
        end
        else if (state_reg == ST_FLUSH && out_free)
        begin
            pend_valid_next = 1'b0;
            move_out        = 1'b1;
        end
    end

    // top-of-stack read follows the pointer so pops run one per cycle while the result side does not stall
    assign count_m1 = count_next - 1'b1;
    assign rd_addr  = count_m1[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (step && do_push)
            stack_mem[count_reg[IDX_W-1:0]] <= push_entry;
        top_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            err_reg        <= ERR_NONE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            if (move_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && tokens.valid)
        begin
            kind_reg <= tokens.kind;
            id_reg   <= tokens.token_id;
            prio_reg <= tokens.priority_req;
            pair_reg <= tokens.bracket_pair;
        end
        if (step && emit_req)
            pend_reg <= emit_res;
        if (move_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= (state_reg == ST_FLUSH);
        end
    end

    // channel outputs
    always_comb
    begin
        tokens.ready        = (state_reg == ST_IDLE);
        results.valid       = out_valid_reg;
        results.out_kind    = out_reg.kind;
        results.out_id      = out_reg.id;
        results.error_code  = out_reg.code;
        results.last_of_run = out_last_reg;
    end

endmodule

`default_nettype wire

### tb/infix_to_postfix_converter_test.sv
// infix_to_postfix_converter_test: self-checking bench for the shunting-yard converter.
// Directed token table, then random expressions, checked against a local stack predictor.
// Depends on itp_pkg, itp_if.sv and the converter RTL.
`default_nettype none

module infix_to_postfix_converter_test;
    import itp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 30;
    localparam int          REPORT_MAX   = 10;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [PAIR_W-1:0] pair;
    } token_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] code;
        logic              last_of_run;
    } emitted_t;

    typedef struct packed {
        token_t   tok;
        logic [5:0] reps;
        logic     typed;
        emitted_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    itp_token_if  tokens_ch();
    itp_result_if results_ch();

    infix_to_postfix_converter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .tokens  (tokens_ch),
        .results (results_ch)
    );

    stack_entry_t      op_stack_copy [STACK_DEPTH];
    int unsigned       stack_fill;
    logic [CODE_W-1:0] held_error;

    emitted_t    postfix_expected[$];
    emitted_t    step_results[$];
    plan_row_t   token_plan[$];
    token_t      sentence[$];

    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned failures;
    int unsigned tokens_sent;
    int unsigned results_checked;
    int unsigned error_results;
    int unsigned overflow_results;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     postfix_expected.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void note(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [CODE_W-1:0] code);
        emitted_t r;
        r.kind        = kind;
        r.id          = id;
        r.code        = code;
        r.last_of_run = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void pop_and_emit();
        stack_entry_t top;
        top = op_stack_copy[stack_fill - 1];
        note(top.cls == CLS_BINARY ? OUT_BINARY : OUT_PREFIX, top.id, ERR_NONE);
        stack_fill--;
    endfunction

    function automatic void raise_error(input logic [CODE_W-1:0] code);
        held_error = code;
        note(OUT_ERROR, '0, code);
    endfunction

    function automatic void push_op(input entry_cls_t cls, input token_t t);
        stack_entry_t e;
        if (stack_fill >= STACK_DEPTH)
            raise_error(ERR_OVERFLOW);
        else
        begin
            e.pair = t.pair;
            e.prio = t.prio;
            e.id   = t.id;
            e.cls  = cls;
            op_stack_copy[stack_fill] = e;
            stack_fill++;
        end
    endfunction

    // Returns 1 when the token did something other than being ignored or dropped.
    function automatic bit predict_postfix(input token_t t);
        stack_entry_t top;
        bit           done;
        step_results.delete();
        if (t.kind == KIND_UNUSED)
            return 1'b0;
        if (held_error != ERR_NONE)
        begin
            if (t.kind != KIND_END)
                return 1'b0;
            note(OUT_END, '0, held_error);
            stack_fill = 0;
            held_error = ERR_NONE;
        end
        else
        begin
            done = 1'b0;
            case (t.kind)
                KIND_OPERAND:
                    note(OUT_OPERAND, t.id, ERR_NONE);
                KIND_POSTFIX:
                    note(OUT_POSTFIX, t.id, ERR_NONE);
                KIND_PREFIX:
                    push_op(CLS_PREFIX, t);
                KIND_OPEN:
                    push_op(CLS_OPEN, t);
                KIND_BINARY:
                begin
                    while (!done && stack_fill > 0)
                    begin
                        top = op_stack_copy[stack_fill - 1];
                        if (top.cls == CLS_OPEN || top.prio < t.prio)
                            done = 1'b1;
                        else
                            pop_and_emit();
                    end
                    push_op(CLS_BINARY, t);
                end
                KIND_CLOSE:
                begin
                    while (!done)
                    begin
                        if (stack_fill == 0)
                        begin
                            raise_error(ERR_BRACKET);
                            done = 1'b1;
                        end
                        else
                        begin
                            top = op_stack_copy[stack_fill - 1];
                            if (top.cls == CLS_OPEN)
                            begin
                                if (top.pair != t.pair)
                                    raise_error(ERR_BRACKET);
                                else
                                    stack_fill--;
                                done = 1'b1;
                            end
                            else
                                pop_and_emit();
                        end
                    end
                end
                default:
                begin
                    while (!done && stack_fill > 0)
                    begin
                        top = op_stack_copy[stack_fill - 1];
                        if (top.cls == CLS_OPEN)
                        begin
                            // unclosed bracket at end: error ends the run, nothing held
                            note(OUT_ERROR, '0, ERR_BRACKET);
                            stack_fill = 0;
                            held_error = ERR_NONE;
                            done       = 1'b1;
                        end
                        else
                            pop_and_emit();
                    end
                    if (!done)
                        note(OUT_END, '0, ERR_NONE);
                end
            endcase
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                          input logic [ID_W-1:0] id,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic [PAIR_W-1:0] pair);
        token_t t;
        t.kind = kind;
        t.id   = id;
        t.prio = prio;
        t.pair = pair;
        return t;
    endfunction

    function automatic void plan_token(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                       input logic [PRIO_W-1:0] prio,
                                       input logic [PAIR_W-1:0] pair, input int reps);
        plan_row_t row;
        row.tok   = make_token(kind, id, prio, pair);
        row.reps  = 6'(reps);
        row.typed = 1'b0;
        row.want  = '0;
        token_plan.push_back(row);
    endfunction

    function automatic void plan_checked(input logic [KIND_W-1:0] kind,
                                         input logic [ID_W-1:0] id,
                                         input logic [PRIO_W-1:0] prio,
                                         input logic [PAIR_W-1:0] pair,
                                         input logic [KIND_W-1:0] out_kind,
                                         input logic [ID_W-1:0] out_id,
                                         input logic [CODE_W-1:0] code);
        plan_row_t row;
        row.tok              = make_token(kind, id, prio, pair);
        row.reps             = 6'd1;
        row.typed            = 1'b1;
        row.want.kind        = out_kind;
        row.want.id          = out_id;
        row.want.code        = code;
        row.want.last_of_run = 1'b1;
        token_plan.push_back(row);
    endfunction

    function automatic void queue_token(input logic [KIND_W-1:0] kind,
                                        input logic [PAIR_W-1:0] pair);
        sentence.push_back(make_token(kind, ID_W'($urandom_range(0, 255)),
                                      PRIO_W'($urandom_range(0, 3)), pair));
    endfunction

    function automatic token_t any_token();
        return make_token(KIND_W'($urandom_range(0, 7)), ID_W'($urandom_range(0, 255)),
                          PRIO_W'($urandom_range(0, 3)), PAIR_W'($urandom_range(0, 3)));
    endfunction

    function automatic void build_term(input int unsigned level);
        logic [PAIR_W-1:0] pair;
        pair = PAIR_W'($urandom_range(0, 3));
        while ($urandom_range(0, 3) == 0)
            queue_token(KIND_PREFIX, pair);
        if (level < 3 && $urandom_range(0, 2) == 0)
        begin
            queue_token(KIND_OPEN, pair);
            build_expr(level + 1);
            queue_token(KIND_CLOSE, pair);
        end
        else
            queue_token(KIND_OPERAND, pair);
        if ($urandom_range(0, 3) == 0)
            queue_token(KIND_POSTFIX, pair);
    endfunction

    function automatic void build_expr(input int unsigned level);
        int unsigned terms;
        terms = $urandom_range(1, 4);
        for (int i = 0; i < terms; i++)
        begin
            if (i > 0)
                queue_token(KIND_BINARY, PAIR_W'($urandom_range(0, 3)));
            build_term(level);
        end
    endfunction

    // Mostly well-formed expressions; some deep nesting, noise and corrupted sentences.
    function automatic void build_sentence();
        int unsigned       shape;
        int unsigned       nest;
        logic [PAIR_W-1:0] pair;
        sentence.delete();
        shape = $urandom_range(0, 19);
        if (shape == 0)
        begin
            nest = $urandom_range(28, 34);
            pair = PAIR_W'($urandom_range(0, 3));
            repeat (nest) queue_token(KIND_OPEN, pair);
            queue_token(KIND_OPERAND, pair);
            repeat (nest) queue_token(KIND_CLOSE, pair);
        end
        else if (shape < 3)
            repeat ($urandom_range(3, 8)) sentence.push_back(any_token());
        else
        begin
            build_expr(0);
            if (shape < 6)
                sentence[$urandom_range(0, sentence.size() - 1)] = any_token();
        end
        queue_token(KIND_END, PAIR_W'($urandom_range(0, 3)));
    endfunction

    task automatic send_token(input token_t t, input bit typed, input emitted_t want,
                              output bit acted);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(30, 60);
                gap        = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 8);
                gap        = $urandom_range(0, 6);
            end
            if (gap != 0)
            begin
                tokens_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        tokens_ch.valid        <= 1'b1;
        tokens_ch.kind         <= t.kind;
        tokens_ch.token_id     <= t.id;
        tokens_ch.priority_req <= t.prio;
        tokens_ch.bracket_pair <= t.pair;
        @(posedge clk);
        while (!tokens_ch.ready)
            @(posedge clk);
        acted = predict_postfix(t);
        if (typed)
            postfix_expected.push_back(want);
        else
            foreach (step_results[i])
                postfix_expected.push_back(step_results[i]);
        tokens_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------- result side

    always @(negedge clk)
    begin : stall_pattern
        static int unsigned mode      = 0;
        static int unsigned mode_left = 0;
        if (mode_left == 0)
        begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 80);
        end
        mode_left--;
        case (mode)
            0: results_ch.ready <= 1'b1;
            1: results_ch.ready <= ($urandom_range(0, 3) != 0);
            2: results_ch.ready <= (cycle_count % 3 == 0);
            default: results_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic string show(input emitted_t r);
        return $sformatf("kind=%0d id=%0d code=%0d last=%0d", r.kind, r.id, r.code,
                         r.last_of_run);
    endfunction

    function automatic void flag_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
    endfunction

    always @(posedge clk)
    begin : result_check
        emitted_t got;
        emitted_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got.kind        = results_ch.out_kind;
            got.id          = results_ch.out_id;
            got.code        = results_ch.error_code;
            got.last_of_run = results_ch.last_of_run;
            if (postfix_expected.size() == 0)
                flag_failure({"unexpected result: ", show(got)});
            else
            begin
                want = postfix_expected.pop_front();
                results_checked++;
                if (want.kind == OUT_ERROR)
                    error_results++;
                if (want.code == ERR_OVERFLOW)
                    overflow_results++;
                if (got.kind != want.kind || got.id != want.id || got.code != want.code
                    || got.last_of_run != want.last_of_run)
                    flag_failure({"expected ", show(want), " got ", show(got)});
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        int unsigned active_items;
        bit          acted;
        rst_n                  = 1'b0;
        tokens_ch.valid        = 1'b0;
        tokens_ch.kind         = '0;
        tokens_ch.token_id     = '0;
        tokens_ch.priority_req = '0;
        tokens_ch.bracket_pair = '0;
        results_ch.ready       = 1'b0;
        stack_fill             = 0;
        held_error             = ERR_NONE;
        active_items           = 0;

        plan_checked(KIND_OPERAND, 8'd0, 2'd0, 2'd0, OUT_OPERAND, 8'd0, ERR_NONE);
        plan_checked(KIND_POSTFIX, 8'd255, 2'd3, 2'd3, OUT_POSTFIX, 8'd255, ERR_NONE);
        plan_checked(KIND_CLOSE, 8'd17, 2'd0, 2'd1, OUT_ERROR, 8'd0, ERR_BRACKET);
        plan_token(KIND_OPERAND, 8'd9, 2'd1, 2'd0, 1);
        plan_checked(KIND_END, 8'd0, 2'd0, 2'd0, OUT_END, 8'd0, ERR_BRACKET);
        plan_token(KIND_UNUSED, 8'd255, 2'd3, 2'd3, 1);
        plan_checked(KIND_END, 8'd255, 2'd3, 2'd3, OUT_END, 8'd0, ERR_NONE);
        plan_token(KIND_PREFIX, 8'd1, 2'd3, 2'd0, 1);
        plan_token(KIND_OPERAND, 8'd2, 2'd0, 2'd0, 1);
        plan_token(KIND_BINARY, 8'd3, 2'd0, 2'd0, 1);
        plan_token(KIND_OPEN, 8'd4, 2'd0, 2'd2, 1);
        plan_token(KIND_OPERAND, 8'd5, 2'd0, 2'd0, 1);
        plan_token(KIND_BINARY, 8'd6, 2'd2, 2'd0, 1);
        plan_token(KIND_PREFIX, 8'd7, 2'd1, 2'd0, 1);
        plan_token(KIND_OPERAND, 8'd8, 2'd0, 2'd0, 1);
        plan_token(KIND_POSTFIX, 8'd9, 2'd0, 2'd0, 1);
        plan_token(KIND_CLOSE, 8'd10, 2'd0, 2'd2, 1);
        plan_token(KIND_END, 8'd11, 2'd0, 2'd0, 1);
        // mismatched pair
        plan_token(KIND_OPEN, 8'd12, 2'd0, 2'd1, 1);
        plan_token(KIND_OPERAND, 8'd13, 2'd0, 2'd0, 1);
        plan_checked(KIND_CLOSE, 8'd14, 2'd0, 2'd3, OUT_ERROR, 8'd0, ERR_BRACKET);
        plan_checked(KIND_END, 8'd15, 2'd0, 2'd0, OUT_END, 8'd0, ERR_BRACKET);
        // bracket left open at end
        plan_token(KIND_OPEN, 8'd16, 2'd0, 2'd0, 1);
        plan_token(KIND_PREFIX, 8'd17, 2'd2, 2'd0, 1);
        plan_token(KIND_END, 8'd18, 2'd0, 2'd0, 1);
        // full stack, prefix push overflows
        plan_token(KIND_OPEN, 8'd19, 2'd0, 2'd3, STACK_DEPTH);
        plan_checked(KIND_PREFIX, 8'd20, 2'd0, 2'd0, OUT_ERROR, 8'd0, ERR_OVERFLOW);
        plan_checked(KIND_END, 8'd21, 2'd0, 2'd0, OUT_END, 8'd0, ERR_OVERFLOW);
        // binary pops a full stack
        plan_token(KIND_PREFIX, 8'hAA, 2'd3, 2'd0, STACK_DEPTH);
        plan_token(KIND_BINARY, 8'h55, 2'd0, 2'd0, 1);
        plan_token(KIND_END, 8'd22, 2'd0, 2'd0, 1);
        // full stack, binary push overflows
        plan_token(KIND_OPEN, 8'd23, 2'd0, 2'd0, STACK_DEPTH);
        plan_checked(KIND_BINARY, 8'd24, 2'd2, 2'd0, OUT_ERROR, 8'd0, ERR_OVERFLOW);
        plan_checked(KIND_END, 8'd25, 2'd0, 2'd0, OUT_END, 8'd0, ERR_OVERFLOW);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (token_plan[i])
            repeat (token_plan[i].reps)
                send_token(token_plan[i].tok, token_plan[i].typed, token_plan[i].want, acted);

        while (active_items < RANDOM_ITEMS)
        begin
            build_sentence();
            foreach (sentence[i])
            begin
                send_token(sentence[i], 1'b0, '0, acted);
                if (acted)
                    active_items++;
            end
        end
        tokens_ch.valid <= 1'b0;

        while (postfix_expected.size() != 0)
            @(posedge clk);
        repeat (2 * STACK_DEPTH + 8) @(posedge clk);

        $display("%0d tokens sent (%0d table rows, %0d random tokens acted on), %0d cycles",
                 tokens_sent, token_plan.size(), active_items, cycle_count);
        $display("%0d results checked, %0d error results, %0d overflow reports, %0d failures",
                 results_checked, error_results, overflow_results, failures);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
